>>> hw/rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants of the set-associative cache model
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package sac_pkg;

	// Fixed field widths.
	localparam int ADDR_W     = 64;
	localparam int AGE_W      = 7;
	localparam int CNT_W      = 48;
	localparam int LAT_W      = 13;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int WAY_OUT_W  = 3;

	// Ages saturate at this value.
	localparam logic [AGE_W-1:0] AGE_MAX = 7'd127;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIT_LATENCY  = 2'd0,
		CFG_MISS_PENALTY = 2'd1,
		CFG_FILL_AS_HIT  = 2'd2
	} sac_cfg_idx_t;

	// Configuration reset values.
	localparam logic [CFG_DATA_W-1:0] HIT_LAT_RST  = 12'd1;
	localparam logic [CFG_DATA_W-1:0] MISS_PEN_RST = 12'd10;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} sac_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic lookup;
		logic update;
	} sac_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} sac_status_t;

endpackage

>>> hw/rtl/set_assoc_cache_lru_model.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model: set-associative cache model with age replacement
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    address
// out      output     out_valid / out_stall  latency, hit, way, access_count,
//                                            hit_count, latency_sum
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An access reads the set row from memory in the accept cycle, searches it
// in the lookup cycle and writes it back in the update cycle.
// The read-modify-write of the set memory sets this order.
// After reset a clearing pass writes every row while the input channel
// stalls. A result waits in its output register under out_stall while the
// next access is accepted; that access's update waits for the register to
// free up.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_model
	import sac_pkg::*;
#(
	parameter int NUM_SETS    = 64,
	parameter int WAYS        = 8,
	parameter int BLOCK_BYTES = 64,
	parameter int TAG_BITS    = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ADDR_W-1:0]     address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LAT_W-1:0]      latency,
	output logic                  hit,
	output logic [WAY_OUT_W-1:0]  way,
	output logic [CNT_W-1:0]      access_count,
	output logic [CNT_W-1:0]      hit_count,
	output logic [CNT_W-1:0]      latency_sum,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	sac_cmd_t    cmd;
	sac_status_t status;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	sac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sac_dpath #(
		.NUM_SETS    (NUM_SETS),
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.TAG_BITS    (TAG_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.address      (address),
		.cfg_wr       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.latency      (latency),
		.hit          (hit),
		.way          (way),
		.access_count (access_count),
		.hit_count    (hit_count),
		.latency_sum  (latency_sum)
	);

	// An accepted access keeps the input side busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an access is in flight");

	// Totals move only together with a new result, never under a waiting one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(access_count) && $stable(hit_count)
			&& $stable(latency_sum)))
		else $error("totals changed while a result was waiting");

	// A new result appears only at the end of an access in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an access in flight");

	// The reported way lies inside the set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((WAYS >= 8) || (int'(way) < WAYS)))
		else $error("way outside the set");

endmodule

>>> hw/rtl/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hw/rtl/sac_ctrl.sv
// ----------------------------------------------------------------------------
// sac_ctrl: sequencing of the set read-modify-write
// Runs the clearing pass after reset, then steps each access through
// accept, lookup and update, and holds the update while the result
// register is still occupied.
// ----------------------------------------------------------------------------
module sac_ctrl
	import sac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  sac_status_t status,
	output sac_cmd_t    cmd
);

	sac_state_t state_q;
	sac_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

>>> hw/rtl/sac_dpath.sv
// ----------------------------------------------------------------------------
// sac_dpath: set memory, tag compare, victim choice, totals and result
// Each memory row holds one whole set: per way a valid bit, a tag and an
// age. A row is read on accept, searched on lookup and written back on
// update, together with the running totals and the result register.
// ----------------------------------------------------------------------------
module sac_dpath
	import sac_pkg::*;
#(
	parameter int NUM_SETS    = 64,
	parameter int WAYS        = 8,
	parameter int BLOCK_BYTES = 64,
	parameter int TAG_BITS    = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sac_cmd_t              cmd,
	output sac_status_t           status,
	input  logic [ADDR_W-1:0]     address,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LAT_W-1:0]      latency,
	output logic                  hit,
	output logic [WAY_OUT_W-1:0]  way,
	output logic [CNT_W-1:0]      access_count,
	output logic [CNT_W-1:0]      hit_count,
	output logic [CNT_W-1:0]      latency_sum
);

	localparam int OFF_W  = $clog2(BLOCK_BYTES);
	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int SET_IW = (NUM_SETS > 1) ? SET_W : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W  = 1 + TAG_BITS + AGE_W;
	localparam int ROW_W  = WAYS * ENT_W;
	localparam logic [SET_IW-1:0] SET_MASK = SET_IW'(NUM_SETS - 1);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] hit_lat_q;
	logic [CFG_DATA_W-1:0] miss_pen_q;
	logic                  fill_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_lat_q  <= HIT_LAT_RST;
			miss_pen_q <= MISS_PEN_RST;
			fill_hit_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_HIT_LATENCY:  hit_lat_q  <= cfg_data;
				CFG_MISS_PENALTY: miss_pen_q <= cfg_data;
				CFG_FILL_AS_HIT:  fill_hit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Address split into set index and tag.
	logic [ADDR_W-1:0]   blk;
	logic [SET_IW-1:0]   set_in;
	logic [TAG_BITS-1:0] tag_in;

	assign blk    = address >> OFF_W;
	assign set_in = SET_IW'(blk) & SET_MASK;
	assign tag_in = TAG_BITS'(blk >> SET_W);

	logic [SET_IW-1:0]   set_q;
	logic [TAG_BITS-1:0] tag_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q <= set_in;
			tag_q <= tag_in;
		end
	end

	// Clearing pass over all rows after reset.
	logic [SET_IW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= (clr_q + SET_IW'(1)) & SET_MASK;
		end
	end

	assign status.clear_last = (clr_q == SET_MASK);

	// Set memory.
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  new_row;
	logic              ram_wr;
	logic [SET_IW-1:0] ram_wr_addr;
	logic [ROW_W-1:0]  ram_wr_data;

	assign ram_wr      = cmd.clear_wr | cmd.update;
	assign ram_wr_addr = cmd.clear_wr ? clr_q : set_q;
	assign ram_wr_data = cmd.clear_wr ? '0 : new_row;

	sac_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (cmd.accept),
		.rd_addr (set_in),
		.rd_data (rd_row)
	);

	// Unpack the row into its ways.
	logic                ent_vld [WAYS];
	logic [TAG_BITS-1:0] ent_tag [WAYS];
	logic [AGE_W-1:0]    ent_age [WAYS];

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			{ent_vld[w], ent_tag[w], ent_age[w]} = rd_row[w*ENT_W +: ENT_W];
		end
	end

	// Tag match and victim choice: first invalid way, else oldest valid way.
	logic             found;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] vic_way;
	logic             vic_empty;
	logic [AGE_W-1:0] top_age;

	always_comb begin
		found     = 1'b0;
		hit_way   = '0;
		vic_way   = '0;
		vic_empty = 1'b0;
		top_age   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && ent_vld[w] && (ent_tag[w] == tag_q)) begin
				found   = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!vic_empty) begin
				if (!ent_vld[w]) begin
					vic_empty = 1'b1;
					vic_way   = WAY_W'(w);
				end else if (ent_age[w] > top_age) begin
					top_age = ent_age[w];
					vic_way = WAY_W'(w);
				end
			end
		end
	end

	// Lookup results.
	logic             found_q;
	logic             empty_q;
	logic [WAY_W-1:0] way_q;

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			found_q <= found;
			empty_q <= !found && vic_empty;
			way_q   <= found ? hit_way : vic_way;
		end
	end

	// Updated row: the used way takes the tag with age zero, other valid
	// ways grow older up to the saturation value.
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == way_q) begin
				new_row[w*ENT_W +: ENT_W] = {1'b1, tag_q, {AGE_W{1'b0}}};
			end else if (ent_vld[w] && (ent_age[w] < AGE_MAX)) begin
				new_row[w*ENT_W +: ENT_W] = {1'b1, ent_tag[w], ent_age[w] + AGE_W'(1)};
			end else begin
				new_row[w*ENT_W +: ENT_W] = {ent_vld[w], ent_tag[w], ent_age[w]};
			end
		end
	end

	// Hit decision and latency of this access.
	logic             hit_now;
	logic [LAT_W-1:0] lat_now;

	assign hit_now = found_q | (fill_hit_q & empty_q);
	assign lat_now = hit_now ? LAT_W'(hit_lat_q) : LAT_W'(hit_lat_q) + LAT_W'(miss_pen_q);

	// Running totals, wrapping at their width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_count <= '0;
			hit_count    <= '0;
			latency_sum  <= '0;
		end else if (cmd.update) begin
			access_count <= access_count + CNT_W'(1);
			hit_count    <= hit_count + CNT_W'(hit_now);
			latency_sum  <= latency_sum + CNT_W'(lat_now);
		end
	end

	// Result register; it frees up when its transfer completes.
	logic out_valid_q;

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			latency <= lat_now;
			hit     <= hit_now;
			way     <= WAY_OUT_W'(way_q);
		end
	end

endmodule

>>> bench/set_assoc_cache_lru_model_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_model_tb: self-checking bench for the cache model
// A queue of addresses feeds a clocked driver, and a clocked monitor checks
// every result against a cycle-free model of the cache kept in this bench.
// The stimulus starts with directed accesses. Random phases follow under
// several register settings, with bursts of idle and stall on both channels.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_model_tb;
	import sac_pkg::*;

	localparam int SETS        = 64;
	localparam int WAYS        = 8;
	localparam int BLOCK_BYTES = 64;
	localparam int TAG_W       = 42;
	localparam int OFF_W       = $clog2(BLOCK_BYTES);
	localparam int SET_W       = $clog2(SETS);
	localparam int RECENT_N    = 16;
	localparam int AGE_RUN_LEN = 135;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PRINT_CAP   = 200;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	// Bits of an address that select the cache line (tag and set).
	localparam logic [ADDR_W-1:0] LINE_MASK = ((64'd1 << (TAG_W + SET_W)) - 64'd1) << OFF_W;

	typedef struct packed {
		logic [LAT_W-1:0]     latency;
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic [CNT_W-1:0]     accesses;
		logic [CNT_W-1:0]     hits;
		logic [CNT_W-1:0]     latency_sum;
	} cache_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [ADDR_W-1:0]     address = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [LAT_W-1:0]      latency;
	logic                  hit;
	logic [WAY_OUT_W-1:0]  way;
	logic [CNT_W-1:0]      access_count;
	logic [CNT_W-1:0]      hit_count;
	logic [CNT_W-1:0]      latency_sum;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Cache contents and totals as the bench expects them.
	logic [TAG_W-1:0]      line_tag   [SETS][WAYS];
	logic                  line_valid [SETS][WAYS];
	logic [AGE_W-1:0]      line_age   [SETS][WAYS];
	logic [CNT_W-1:0]      access_total;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      latency_total;

	// Register copies.
	logic [CFG_DATA_W-1:0] hit_lat_cfg;
	logic [CFG_DATA_W-1:0] miss_pen_cfg;
	logic                  fill_as_hit_cfg;

	logic [ADDR_W-1:0]     pending_addr_q [$];
	cache_result_t         expected_access_q [$];
	cache_result_t         want_r;
	logic [ADDR_W-1:0]     recent_addr [RECENT_N];
	int unsigned           recent_wr;

	int in_idle_pct;
	int out_stall_pct;
	int in_gap;
	int out_gap;
	int errors;
	int items_sent;
	int results_checked;
	int hits_seen;
	int cfg_writes;
	int cycle_count;

	set_assoc_cache_lru_model #(
		.NUM_SETS   (SETS),
		.WAYS       (WAYS),
		.BLOCK_BYTES(BLOCK_BYTES),
		.TAG_BITS   (TAG_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.address     (address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.latency     (latency),
		.hit         (hit),
		.way         (way),
		.access_count(access_count),
		.hit_count   (hit_count),
		.latency_sum (latency_sum),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Free-running clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Look up one address, update the cache copy and return the result.
	function automatic cache_result_t predict_cache_access(input logic [ADDR_W-1:0] addr);
		logic [ADDR_W-1:0] blk;
		logic [TAG_W-1:0]  tag;
		int unsigned       set_i;
		int unsigned       used_way;
		logic              found;
		logic              have_empty;
		logic              counted_hit;
		logic [AGE_W-1:0]  top;
		logic [LAT_W-1:0]  lat;
		cache_result_t     r;
		blk = addr >> OFF_W;
		set_i = 32'(blk % SETS);
		tag = TAG_W'(blk >> SET_W);
		found = 1'b0;
		used_way = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && line_valid[set_i][w] && line_tag[set_i][w] == tag) begin
				found = 1'b1;
				used_way = w;
			end
		end
		counted_hit = found;
		if (!found) begin
			// First empty way, else the lowest way with the strictly largest age.
			have_empty = 1'b0;
			top = '0;
			for (int w = 0; w < WAYS; w++) begin
				if (!have_empty) begin
					if (!line_valid[set_i][w]) begin
						used_way = w;
						have_empty = 1'b1;
					end else if (line_age[set_i][w] > top) begin
						top = line_age[set_i][w];
						used_way = w;
					end
				end
			end
			counted_hit = fill_as_hit_cfg && have_empty;
			line_tag[set_i][used_way] = tag;
			line_valid[set_i][used_way] = 1'b1;
		end
		// Age the other valid ways, saturating, and renew the used one.
		for (int w = 0; w < WAYS; w++) begin
			if (line_valid[set_i][w] && w != used_way && line_age[set_i][w] < AGE_MAX)
				line_age[set_i][w] = line_age[set_i][w] + AGE_W'(1);
		end
		line_age[set_i][used_way] = '0;
		lat = counted_hit ? LAT_W'(hit_lat_cfg) : LAT_W'(hit_lat_cfg) + LAT_W'(miss_pen_cfg);
		access_total = access_total + CNT_W'(1);
		if (counted_hit)
			hit_total = hit_total + CNT_W'(1);
		latency_total = latency_total + CNT_W'(lat);
		r.latency = lat;
		r.hit = counted_hit;
		r.way = WAY_OUT_W'(used_way);
		r.accesses = access_total;
		r.hits = hit_total;
		r.latency_sum = latency_total;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] make_address(input logic [TAG_W-1:0] tag,
			input logic [SET_W-1:0] set_i, input logic [OFF_W-1:0] offset,
			input logic [ADDR_W-1:0] high_bits);
		logic [ADDR_W-1:0] a;
		a = (ADDR_W'(tag) << (OFF_W + SET_W)) | (ADDR_W'(set_i) << OFF_W) | ADDR_W'(offset);
		return a | (high_bits << (OFF_W + SET_W + TAG_W));
	endfunction

	// Small tag pool: low values and values near all ones.
	function automatic logic [TAG_W-1:0] pool_tag(input int unsigned k);
		if (k < 6)
			return TAG_W'(k);
		return ~TAG_W'(k - 6);
	endfunction

	// Mostly reuse within a few hot sets, plus aliases of recent lines and noise.
	function automatic logic [ADDR_W-1:0] random_address();
		int unsigned       pick;
		int unsigned       k;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] noise;
		pick = $urandom_range(0, 99);
		noise = {$urandom, $urandom};
		if (pick < 55) begin
			k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 11);
			a = make_address(pool_tag(k), SET_W'(7 + 18 * $urandom_range(0, 3)),
				OFF_W'(noise), noise >> 32);
		end else if (pick < 70) begin
			// Same line, other offset and other bits above the tag.
			a = (recent_addr[$urandom_range(0, RECENT_N - 1)] & LINE_MASK) | (noise & ~LINE_MASK);
		end else if (pick < 90) begin
			a = noise;
		end else begin
			a = make_address(pool_tag($urandom_range(0, 3)), SET_W'($urandom),
				OFF_W'(noise), noise >> 32);
		end
		recent_addr[recent_wr] = a;
		recent_wr = (recent_wr + 1) % RECENT_N;
		return a;
	endfunction

	task automatic check_field(input string field, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			if (errors < PRINT_CAP)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// One register write; the copy changes on the edge of the transfer.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_HIT_LATENCY:  hit_lat_cfg = data;
			CFG_MISS_PENALTY: miss_pen_cfg = data;
			CFG_FILL_AS_HIT:  fill_as_hit_cfg = data[0];
			default:          ;
		endcase
	endtask

	// Wait until every queued address is sent and every result is back.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_addr_q.size() != 0 || in_valid || expected_access_q.size() != 0);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			pending_addr_q.push_back(random_address());
	endtask

	// Address driver: one transfer per accepted address.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			address  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_access_q.push_back(predict_cache_access(address));
				items_sent++;
			end
			// Present the next address, or idle, once the current one is taken.
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_addr_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if ($urandom_range(0, 99) < in_idle_pct) begin
					in_gap = $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					address  <= pending_addr_q.pop_front();
				end
			end
		end
	end

	// Result monitor with random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_access_q.size() == 0) begin
					if (errors < PRINT_CAP)
						$display("%0t ns: result transfer with nothing expected, latency %0d way %0d",
							$time, latency, way);
					errors++;
				end else begin
					want_r = expected_access_q.pop_front();
					check_field("latency", CNT_W'(want_r.latency), CNT_W'(latency));
					check_field("hit", CNT_W'(want_r.hit), CNT_W'(hit));
					check_field("way", CNT_W'(want_r.way), CNT_W'(way));
					check_field("access_count", want_r.accesses, access_count);
					check_field("hit_count", want_r.hits, hit_count);
					check_field("latency_sum", want_r.latency_sum, latency_sum);
					results_checked++;
					if (hit === 1'b1)
						hits_seen++;
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < out_stall_pct) begin
				out_gap = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Run time limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		// Cache copy and registers start from their reset state.
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				line_tag[s][w] = '0;
				line_valid[s][w] = 1'b0;
				line_age[s][w] = '0;
			end
		end
		for (int i = 0; i < RECENT_N; i++)
			recent_addr[i] = '0;
		access_total = '0;
		hit_total = '0;
		latency_total = '0;
		hit_lat_cfg = HIT_LAT_RST;
		miss_pen_cfg = MISS_PEN_RST;
		fill_as_hit_cfg = 1'b0;
		in_idle_pct = 15;
		out_stall_pct = 15;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed accesses under the reset settings.
		pending_addr_q.push_back(64'h0);                    // miss into empty set 0
		pending_addr_q.push_back(64'h0);                    // hit
		pending_addr_q.push_back(64'h3F);                   // hit at the last offset
		pending_addr_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);  // all ones: last set, full tag
		pending_addr_q.push_back(64'h003F_FFFF_FFFF_FFFF);  // bits above the tag ignored
		// Fill set 1, then one more tag evicts the oldest way.
		for (int k = 1; k <= 9; k++)
			pending_addr_q.push_back(make_address(TAG_W'(k), SET_W'(1), '0, '0));
		pending_addr_q.push_back(make_address(TAG_W'(1), SET_W'(1), '0, '0));
		pending_addr_q.push_back(make_address(TAG_W'(9), SET_W'(1), '0, '0));
		pending_addr_q.push_back(64'h8000_0000_0000_0000);  // top bit only: set 0, tag 0
		pending_addr_q.push_back(64'h0000_0000_0000_1000);  // tag 1 in set 0
		wait_drained();

		// Largest latencies; fill of an empty way counts as a hit (upper data bits dropped).
		write_register(CFG_HIT_LATENCY, 12'hFFF);
		write_register(CFG_MISS_PENALTY, 12'hFFF);
		write_register(CFG_FILL_AS_HIT, 12'hFFF);
		write_register(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
		in_idle_pct = 25;
		out_stall_pct = 25;
		queue_random(200);
		wait_drained();

		// Zero latencies; fills are misses again.
		write_register(CFG_HIT_LATENCY, 12'h000);
		write_register(CFG_MISS_PENALTY, 12'h000);
		write_register(CFG_FILL_AS_HIT, 12'hFFE);
		in_idle_pct = 5;
		out_stall_pct = 40;
		queue_random(150);
		wait_drained();

		// Random latencies, plus one long run that saturates ages in one set:
		// fill eight ways, hammer the last, then two new tags break the tie.
		write_register(CFG_HIT_LATENCY, CFG_DATA_W'($urandom));
		write_register(CFG_MISS_PENALTY, CFG_DATA_W'($urandom));
		write_register(CFG_FILL_AS_HIT, 12'h001);
		in_idle_pct = 40;
		out_stall_pct = 5;
		queue_random(100);
		for (int k = 0; k < WAYS; k++)
			pending_addr_q.push_back(make_address(TAG_W'(100 + k), SET_W'(33), OFF_W'(k), '0));
		for (int i = 0; i < AGE_RUN_LEN; i++)
			pending_addr_q.push_back(make_address(TAG_W'(100 + WAYS - 1), SET_W'(33),
				OFF_W'($urandom), {$urandom, $urandom}));
		pending_addr_q.push_back(make_address(TAG_W'(200), SET_W'(33), '0, '0));
		pending_addr_q.push_back(make_address(TAG_W'(100), SET_W'(33), '0, '0));
		queue_random(100);
		wait_drained();

		write_register(CFG_HIT_LATENCY, 12'h000);
		write_register(CFG_MISS_PENALTY, 12'hFFF);
		write_register(CFG_FILL_AS_HIT, 12'h000);
		in_idle_pct = 15;
		out_stall_pct = 15;
		queue_random(150);
		wait_drained();

		// Final phase runs without idle or stall bursts on both channels.
		write_register(CFG_HIT_LATENCY, CFG_DATA_W'($urandom));
		write_register(CFG_MISS_PENALTY, 12'h000);
		write_register(CFG_FILL_AS_HIT, 12'h001);
		in_idle_pct = 0;
		out_stall_pct = 0;
		queue_random(200);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d addresses and checked %0d results, %0d of them hits.",
			items_sent, results_checked, hits_seen);
		$display("Six register settings over %0d writes, latencies at 0 and 4095 included.",
			cfg_writes);
		if (errors == 0 && expected_access_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
